/* rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and codes for the register script interpreter
// Opcodes, parser phase codes and the structs passed between the
// parser decode and the top level.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Script opcodes
  localparam logic [7:0] OP_DELAY = 8'hfe;
  localparam logic [7:0] OP_BURST = 8'hfd;
  localparam logic [7:0] OP_TEXT  = 8'hf0;

  // Parser phase codes
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_DELAY_ARG   = 3'd1;
  localparam logic [2:0] PH_TEXT_COUNT  = 3'd2;
  localparam logic [2:0] PH_TEXT_SKIP   = 3'd3;
  localparam logic [2:0] PH_BURST_COUNT = 3'd4;
  localparam logic [2:0] PH_BURST_ADDR  = 3'd5;
  localparam logic [2:0] PH_BURST_DATA  = 3'd6;
  localparam logic [2:0] PH_WRITE_VALUE = 3'd7;

  // Action kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_DELAY = 1'b1;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] pending_address;
    logic [7:0] bytes_remaining;
  } parse_state_t;

  typedef struct packed {
    logic       action_kind;
    logic [7:0] reg_address;
    logic [7:0] reg_value;
    logic [7:0] delay_ms;
  } action_t;

endpackage

/* rtl/rsi_if.sv */
// ----------------------------------------------------------------------------
// rsi_if: request channels of the register script interpreter
// Script byte channel and action channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       last_byte;

  modport source (output valid, output script_byte, output last_byte, input ready);
  modport sink   (input valid, input script_byte, input last_byte, output ready);
endinterface

interface rsi_out_if;
  logic       valid;
  logic       ready;
  logic       action_kind;
  logic [7:0] reg_address;
  logic [7:0] reg_value;
  logic [7:0] delay_ms;

  modport source (output valid, output action_kind, output reg_address,
                  output reg_value, output delay_ms, input ready);
  modport sink   (input valid, input action_kind, input reg_address,
                  input reg_value, input delay_ms, output ready);
endinterface

/* rtl/rsi_parser.sv */
// ----------------------------------------------------------------------------
// rsi_parser: one-byte step of the script parser
// From the current parser state and one script byte, computes the next
// state and at most one action (register write or delay request).
// ----------------------------------------------------------------------------
module rsi_parser (
  input  rsi_pkg::parse_state_t cur,
  input  logic [7:0]            script_byte,
  input  logic                  last_byte,
  output rsi_pkg::parse_state_t nxt,
  output logic                  emit,
  output rsi_pkg::action_t      act
);
  import rsi_pkg::*;

  logic [7:0] count_less_one;

  // count byte n leaves n-1 bytes, zero stays zero
  assign count_less_one = (script_byte != 8'd0) ? script_byte - 8'd1 : 8'd0;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    act  = '0;

    case (cur.phase)
      PH_DELAY_ARG: begin
        emit          = 1'b1;
        act.action_kind = ACT_DELAY;
        act.delay_ms  = script_byte;
        nxt.phase     = PH_IDLE;
      end
      PH_TEXT_COUNT: begin
        nxt.bytes_remaining = count_less_one;
        nxt.phase = (count_less_one != 8'd0) ? PH_TEXT_SKIP : PH_IDLE;
      end
      PH_TEXT_SKIP: begin
        nxt.bytes_remaining = cur.bytes_remaining - 8'd1;
        if (cur.bytes_remaining == 8'd1) begin
          nxt.phase = PH_IDLE;
        end
      end
      PH_BURST_COUNT: begin
        nxt.bytes_remaining = count_less_one;
        nxt.phase = PH_BURST_ADDR;
      end
      PH_BURST_ADDR: begin
        nxt.pending_address = script_byte;
        nxt.phase = (cur.bytes_remaining != 8'd0) ? PH_BURST_DATA : PH_IDLE;
      end
      PH_BURST_DATA: begin
        emit = 1'b1;
        act.action_kind     = ACT_WRITE;
        act.reg_address     = cur.pending_address;
        act.reg_value       = script_byte;
        nxt.pending_address = cur.pending_address + 8'd1;
        nxt.bytes_remaining = cur.bytes_remaining - 8'd1;
        if (cur.bytes_remaining == 8'd1) begin
          nxt.phase = PH_IDLE;
        end
      end
      PH_WRITE_VALUE: begin
        emit = 1'b1;
        act.action_kind = ACT_WRITE;
        act.reg_address = cur.pending_address;
        act.reg_value   = script_byte;
        nxt.phase       = PH_IDLE;
      end
      default: begin
        // idle: opcode or plain register address
        if (script_byte == OP_DELAY) begin
          nxt.phase = PH_DELAY_ARG;
        end else if (script_byte == OP_BURST) begin
          nxt.phase = PH_BURST_COUNT;
        end else if (script_byte == OP_TEXT) begin
          nxt.phase = PH_TEXT_COUNT;
        end else begin
          nxt.pending_address = script_byte;
          nxt.phase = PH_WRITE_VALUE;
        end
      end
    endcase

    // final byte of the script drops any unfinished record
    if (last_byte) begin
      nxt.phase           = PH_IDLE;
      nxt.bytes_remaining = 8'd0;
    end
  end

endmodule

/* rtl/register_script_interpreter_unit.sv */
// ----------------------------------------------------------------------------
// register_script_interpreter_unit: register init script interpreter
// Turns a byte stream of a device setup script into register writes and
// delay requests.
//
// Channels: script_in carries one script byte per request with a flag on
// the final byte; action_out carries one action per request: a register
// write (address, value) or a delay request in milliseconds.
// Output: an action appears on action_out in the cycle after the byte that
// completes it is accepted. Bytes that only advance the parser give none.
// Throughput: one byte per cycle while action_out accepts, set by the single
// output register; a byte is taken in the same cycle the pending action is.
// Stall: while action_out is held off, the output register keeps its action
// and script_in.ready stays low, so no byte is lost.
// Reset: rst (synchronous) returns the parser to idle and empties the
// output register. The final-byte flag also returns the parser to idle and
// discards a record that is still incomplete.
// ----------------------------------------------------------------------------
module register_script_interpreter_unit (
  input logic         clk,
  input logic         rst,
  rsi_in_if.sink      script_in,
  rsi_out_if.source   action_out
);
  import rsi_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  logic         step_emit;
  action_t      step_act;
  logic         out_valid;
  action_t      out_act;
  logic         in_fire;

  // step decode
  rsi_parser u_parser (
    .cur         (state),
    .script_byte (script_in.script_byte),
    .last_byte   (script_in.last_byte),
    .nxt         (state_next),
    .emit        (step_emit),
    .act         (step_act)
  );

  // accept whenever the output register is free or being drained
  assign script_in.ready = !out_valid || action_out.ready;
  assign in_fire         = script_in.valid && script_in.ready;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= step_emit;
    end else if (action_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire && step_emit) begin
      out_act <= step_act;
    end
  end

  assign action_out.valid       = out_valid;
  assign action_out.action_kind = out_act.action_kind;
  assign action_out.reg_address = out_act.reg_address;
  assign action_out.reg_value   = out_act.reg_value;
  assign action_out.delay_ms    = out_act.delay_ms;

  // checks
  a_delay_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_act.action_kind == ACT_DELAY) |->
      (out_act.reg_address == 8'd0 && out_act.reg_value == 8'd0))
    else $error("delay action carries write fields");

  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_act.action_kind == ACT_WRITE) |-> (out_act.delay_ms == 8'd0))
    else $error("write action carries a delay");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && script_in.last_byte) |=>
      (state.phase == PH_IDLE && state.bytes_remaining == 8'd0))
    else $error("parser not idle after final byte");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_BURST_DATA || state.phase == PH_TEXT_SKIP) |->
      (state.bytes_remaining != 8'd0))
    else $error("data or skip phase with no bytes left");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("action appeared without an accepted byte");

endmodule
